>>> sv/gble_pkg.sv
// Shared types and constants for the grid likelihood estimator.
// No dependencies; imported by gble_ctrl, gble_dp and the top level.
`default_nettype none
package gble_pkg;

  localparam int IDX_W  = 8;
  localparam int CELL_W = 32;
  localparam int LOG_W  = 21;   // 5 integer bits, 16 fraction bits
  localparam int STEP_W = 5;

  localparam logic [IDX_W-1:0]  LAST_IDX   = 8'hFF;
  localparam logic [CELL_W-1:0] UNIFORM    = 32'h0100_0000;
  localparam logic [15:0]       LN2_Q16    = 16'd45426;
  localparam logic [39:0]       THR16      = 40'd687194767;
  localparam logic [39:0]       THR50      = 40'd2147483648;
  localparam logic [39:0]       THR84      = 40'd3607772528;
  localparam logic [STEP_W-1:0] LOG_STEPS  = 5'd15;
  localparam logic [STEP_W-1:0] DIV_STEPS  = 5'd31;

  typedef enum logic [1:0] {
    LSRC_BACK  = 2'd0,
    LSRC_FRONT = 2'd1,
    LSRC_POS   = 2'd2
  } log_src_t;

  typedef struct packed {
    logic             accept;
    logic             restart;
    logic             log_load;
    log_src_t         log_src;
    logic             log_step;
    logic             cap_lb;
    logic             set_base;
    logic             cell_rd;
    logic             mag;
    logic             den;
    logic             div_load;
    logic             div_step;
    logic             mul_u;
    logic             acc;
    logic             norm_rd;
    logic             norm_load;
    logic             norm_step;
    logic             norm_wr;
    logic             scan_init;
    logic             scan_rd;
    logic             scan_proc;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic energy_zero;
    logic sum_zero;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/gble_ctrl.sv
// Sequencer for the estimator: walks the log, weighting, normalising and scan passes.
// Depends on gble_pkg; drives gble_dp through cmd_t and reads sts_t.
`default_nettype none
module gble_ctrl import gble_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic op,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_LOGB_LD = 20'h00002,
    S_LOGB    = 20'h00004,
    S_LOGF_LD = 20'h00008,
    S_LOGF    = 20'h00010,
    S_BASE    = 20'h00020,
    S_CELL    = 20'h00040,
    S_LOGX    = 20'h00080,
    S_DIST    = 20'h00100,
    S_DEN     = 20'h00200,
    S_DIVLD   = 20'h00400,
    S_DIV     = 20'h00800,
    S_MULU    = 20'h01000,
    S_ACC     = 20'h02000,
    S_NCHK    = 20'h04000,
    S_NRD     = 20'h08000,
    S_NLD     = 20'h10000,
    S_NDIV    = 20'h20000,
    S_NWR     = 20'h40000,
    S_SCAN    = 20'h80000
  } state_t;

  // scan uses two sub-phases tracked by a flag
  state_t             state, state_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               phase, phase_next;   // scan: 0 read, 1 process
  logic               fin, fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      step  <= '0;
      phase <= 1'b0;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      step  <= step_next;
      phase <= phase_next;
      fin   <= fin_next;
    end
  end

  assign busy = (state != S_IDLE) || fin;
  assign done = fin;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    step_next  = step;
    phase_next = phase;
    fin_next   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.log_src = LSRC_BACK;
    unique case (state)
      S_IDLE: begin
        if (start && !fin) begin
          cmd.accept = 1'b1;
          if (op) begin
            cmd.restart = 1'b1;
            state_next  = S_SCAN;
          end else if (sts.energy_zero) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_LOGB_LD;
          end
          idx_next   = '0;
          phase_next = 1'b0;
        end
      end
      S_LOGB_LD: begin
        cmd.log_load = 1'b1;
        cmd.log_src  = LSRC_BACK;
        step_next    = '0;
        state_next   = S_LOGB;
      end
      S_LOGB: begin
        cmd.log_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LOG_STEPS) state_next = S_LOGF_LD;
      end
      S_LOGF_LD: begin
        cmd.cap_lb   = 1'b1;
        cmd.log_load = 1'b1;
        cmd.log_src  = LSRC_FRONT;
        step_next    = '0;
        state_next   = S_LOGF;
      end
      S_LOGF: begin
        cmd.log_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LOG_STEPS) state_next = S_BASE;
      end
      S_BASE: begin
        cmd.set_base = 1'b1;
        idx_next     = '0;
        state_next   = S_CELL;
      end
      S_CELL: begin
        cmd.cell_rd  = 1'b1;
        cmd.log_load = 1'b1;
        cmd.log_src  = LSRC_POS;
        step_next    = '0;
        state_next   = S_LOGX;
      end
      S_LOGX: begin
        cmd.log_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == LOG_STEPS) state_next = S_DIST;
      end
      S_DIST: begin
        cmd.mag    = 1'b1;
        state_next = S_DEN;
      end
      S_DEN: begin
        cmd.den    = 1'b1;
        state_next = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == DIV_STEPS) state_next = S_MULU;
      end
      S_MULU: begin
        cmd.mul_u  = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        idx_next   = idx + 1'b1;
        state_next = (idx == LAST_IDX) ? S_NCHK : S_CELL;
      end
      S_NCHK: begin
        idx_next   = '0;
        phase_next = 1'b0;
        state_next = sts.sum_zero ? S_SCAN : S_NRD;
      end
      S_NRD: begin
        cmd.norm_rd = 1'b1;
        state_next  = S_NLD;
      end
      S_NLD: begin
        cmd.norm_load = 1'b1;
        step_next     = '0;
        state_next    = S_NDIV;
      end
      S_NDIV: begin
        cmd.norm_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == DIV_STEPS) state_next = S_NWR;
      end
      S_NWR: begin
        cmd.norm_wr = 1'b1;
        idx_next    = idx + 1'b1;
        phase_next  = 1'b0;
        state_next  = (idx == LAST_IDX) ? S_SCAN : S_NRD;
      end
      S_SCAN: begin
        // idx is 0 on entry; first read cycle also clears the scan registers
        if (!phase) begin
          cmd.scan_rd   = 1'b1;
          cmd.scan_init = (idx == '0);
          phase_next    = 1'b1;
        end else begin
          cmd.scan_proc = 1'b1;
          phase_next    = 1'b0;
          idx_next      = idx + 1'b1;
          if (idx == LAST_IDX) begin
            state_next = S_IDLE;
            fin_next   = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/gble_dp.sv
// Datapath: grid and weight memories, shared log2 unit, bit-serial dividers, scan.
// Depends on gble_pkg; sequenced by gble_ctrl through cmd_t.
`default_nettype none
module gble_dp import gble_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               op,
  input  logic [15:0]        front_energy,
  input  logic [15:0]        back_energy,
  input  logic [23:0]        grid_low,
  input  logic [23:0]        grid_high,
  input  logic [15:0]        lorentz_width,
  output logic [IDX_W-1:0]   peak_index,
  output logic [CELL_W-1:0]  peak_value,
  output logic [IDX_W-1:0]   p16_index,
  output logic [IDX_W-1:0]   p50_index,
  output logic [IDX_W-1:0]   p84_index,
  output logic [2:0]         found_flags,
  output logic [31:0]        event_count,
  output logic               input_error
);

  logic [15:0] front_q, back_q;

  // ---- log2 unit: integer part by priority encode, fraction by squaring ----
  logic [23:0]      lg_in;
  logic [4:0]       lg_msb;
  logic [30:0]      lg_m, lg_shift;
  logic [15:0]      lg_frac;
  logic [4:0]       lg_int;
  logic [61:0]      lg_sq;
  logic [31:0]      lg_m2;
  logic [LOG_W-1:0] lg_res, lb;

  // ---- positions ----
  logic        up;
  logic [23:0] diff, off, x_raw, pos_x;
  logic [31:0] xacc;

  // ---- weighting ----
  logic signed [23:0] base, dl;
  logic [22:0]        a_abs, d;
  logic [38:0]        d_prod;
  logic [39:0]        w2;
  logic [19:0]        w16;
  logic [46:0]        den, r;
  logic [47:0]        r2;
  logic               r_ge, sat;
  logic [31:0]        q, g;
  logic [CELL_W-1:0]  c, cell_v;
  logic [47:0]        u;
  logic [56:0]        sum;

  // ---- normalising ----
  logic [47:0] u_q;
  logic [56:0] nr;
  logic [57:0] nr2;
  logic        n_ge, n_ge0;
  logic [32:0] nq;

  // ---- memories ----
  logic [CELL_W-1:0] grid_mem [256];
  logic [47:0]       u_mem [256];
  logic [255:0]      valid;
  logic [CELL_W-1:0] grid_q;
  logic              valid_q;

  // ---- scan ----
  logic [39:0] cum, cum_n;

  assign sts.energy_zero = (front_energy == 16'd0) || (back_energy == 16'd0);
  assign sts.sum_zero    = (sum == '0);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      front_q     <= front_energy;
      back_q      <= back_energy;
      input_error <= !op && ((front_energy == 16'd0) || (back_energy == 16'd0));
    end
  end

  // positions advance by diff/256 per cell, accumulated exactly
  assign up    = (grid_high >= grid_low);
  assign diff  = up ? (grid_high - grid_low) : (grid_low - grid_high);
  assign off   = xacc[31:8];
  assign x_raw = up ? (grid_low + off) : (grid_low - off);
  assign pos_x = (x_raw == '0) ? 24'd1 : x_raw;

  always_comb begin
    case (cmd.log_src)
      LSRC_BACK:  lg_in = {8'd0, back_q};
      LSRC_FRONT: lg_in = {8'd0, front_q};
      LSRC_POS:   lg_in = pos_x;
      default:    lg_in = 24'd1;
    endcase
  end

  always_comb begin
    lg_msb = '0;
    for (int b = 0; b < 24; b++) begin
      if (lg_in[b]) lg_msb = 5'(b);
    end
  end

  assign lg_shift = {7'd0, lg_in} << (5'd30 - lg_msb);
  assign lg_sq    = {31'd0, lg_m} * {31'd0, lg_m};
  assign lg_m2    = lg_sq[61:30];
  assign lg_res   = {lg_int, lg_frac};

  always_ff @(posedge clk) begin
    if (cmd.log_load) begin
      lg_m    <= lg_shift;
      lg_int  <= lg_msb;
      lg_frac <= '0;
    end else if (cmd.log_step) begin
      lg_frac <= {lg_frac[14:0], lg_m2[31]};
      lg_m    <= lg_m2[31] ? lg_m2[31:1] : lg_m2[30:0];
    end
    if (cmd.cap_lb) lb <= lg_res;
  end

  // ---- per-cell weight 2^61 / (w^2 + d^2) ----
  assign w16    = {lorentz_width, 4'd0};
  assign dl     = base - $signed({3'd0, lg_res});
  assign a_abs  = dl[23] ? 23'(-dl) : 23'(dl);
  assign d_prod = {16'd0, a_abs} * {23'd0, LN2_Q16} + 39'd32768;
  assign cell_v = valid_q ? grid_q : UNIFORM;
  assign r2     = {r, 1'b0};
  assign r_ge   = (r2 >= {1'b0, den});
  assign g      = sat ? 32'hFFFF_FFFF : q;

  always_ff @(posedge clk) begin
    if (cmd.set_base) begin
      base <= $signed({3'd0, lb}) - $signed({3'd0, lg_res}) + 24'sd1048576;
      w2   <= {20'd0, w16} * {20'd0, w16};
    end
    if (cmd.mag) begin
      d <= d_prod[38:16];
      c <= cell_v;
    end
    if (cmd.den) den <= {7'd0, w2} + 47'({23'd0, d} * {23'd0, d});
    if (cmd.div_load) begin
      sat <= (den <= 47'd536870912);
      r   <= 47'd536870912;
      q   <= '0;
    end else if (cmd.div_step) begin
      r <= r_ge ? 47'(r2 - {1'b0, den}) : r2[46:0];
      q <= {q[30:0], r_ge};
    end
    if (cmd.mul_u) u <= 48'(({32'd0, c} * {32'd0, g}) >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count <= '0;
      sum         <= '0;
      xacc        <= '0;
    end else begin
      if (cmd.restart) event_count <= '0;
      else if (cmd.set_base && (event_count != 32'hFFFF_FFFF))
        event_count <= event_count + 1'b1;
      if (cmd.set_base) begin
        sum  <= '0;
        xacc <= '0;
      end else if (cmd.acc) begin
        sum  <= sum + {9'd0, u};
        xacc <= xacc + {8'd0, diff};
      end
    end
  end

  // ---- normalising divider: floor(u * 2^32 / sum) ----
  assign n_ge0 = ({9'd0, u_q} >= sum);
  assign nr2   = {nr, 1'b0};
  assign n_ge  = (nr2 >= {1'b0, sum});

  always_ff @(posedge clk) begin
    if (cmd.norm_load) begin
      nr <= n_ge0 ? ({9'd0, u_q} - sum) : {9'd0, u_q};
      nq <= {32'd0, n_ge0};
    end else if (cmd.norm_step) begin
      nr <= n_ge ? 57'(nr2 - {1'b0, sum}) : nr2[56:0];
      nq <= {nq[31:0], n_ge};
    end
  end

  // ---- memories ----
  always_ff @(posedge clk) begin
    if (cmd.norm_wr) grid_mem[cmd.idx] <= nq[32] ? 32'hFFFF_FFFF : nq[31:0];
    if (cmd.cell_rd || cmd.scan_rd) begin
      grid_q  <= grid_mem[cmd.idx];
      valid_q <= valid[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) u_mem[cmd.idx] <= u;
    if (cmd.norm_rd) u_q <= u_mem[cmd.idx];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) valid <= '0;
    else if (cmd.norm_wr) valid[cmd.idx] <= 1'b1;
  end

  // ---- peak and percentile scan ----
  assign cum_n = cum + {8'd0, cell_v};

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cum         <= '0;
      found_flags <= '0;
      p16_index   <= LAST_IDX;
      p50_index   <= LAST_IDX;
      p84_index   <= LAST_IDX;
      peak_index  <= '0;
      peak_value  <= '0;
    end else if (cmd.scan_proc) begin
      if ((cmd.idx == '0) || (cell_v > peak_value)) begin
        peak_index <= cmd.idx;
        peak_value <= cell_v;
      end
      if (cmd.idx != LAST_IDX) begin
        cum <= cum_n;
        if (!found_flags[0] && (cum_n > THR16)) begin
          p16_index      <= cmd.idx;
          found_flags[0] <= 1'b1;
        end
        if (!found_flags[1] && (cum_n > THR50)) begin
          p50_index      <= cmd.idx;
          found_flags[1] <= 1'b1;
        end
        if (!found_flags[2] && (cum_n > THR84)) begin
          p84_index      <= cmd.idx;
          found_flags[2] <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/grid_bayes_lorentz_estimator.sv
// Top level of the grid Bayesian estimator with Cauchy-Lorentz likelihood.
// Depends on gble_pkg, gble_ctrl and gble_dp; holds the APB register file.
//
//  channel   handshake              payload
//  ------    ---------              -------
//  command   start & !busy          op, front_energy, back_energy
//  result    done (one cycle)       peak_index .. input_error
//  config    psel&penable&pwrite    paddr, pwdata (prdata on read)
//
// An energy event is handled in passes: two 16-step log2 runs, then per cell
// 16 log2 squaring steps and a 32-step reciprocal divider, then a normalising
// divide per cell, then a scan that reads and then processes each cell. If the
// weighted sum is zero the normalising pass is skipped.
// A restart or a zero-energy event runs only the scan.
// Reset sets the grid uniform at once (per-cell valid bits); no clearing pass.
// Each result is held for one cycle under done; the receiver cannot stall.
`default_nettype none
module grid_bayes_lorentz_estimator import gble_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // command transfer
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [15:0]       front_energy,
  input  logic [15:0]       back_energy,
  // result transfer
  output logic              done,
  output logic [IDX_W-1:0]  peak_index,
  output logic [CELL_W-1:0] peak_value,
  output logic [IDX_W-1:0]  p16_index,
  output logic [IDX_W-1:0]  p50_index,
  output logic [IDX_W-1:0]  p84_index,
  output logic [2:0]        found_flags,
  output logic [31:0]       event_count,
  output logic              input_error,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [1:0] REG_LOW   = 2'd0;
  localparam logic [1:0] REG_HIGH  = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;

  logic [23:0] grid_low, grid_high;
  logic [15:0] lorentz_width;
  logic        wr;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // user must change registers only while idle (unenforced); no hand-over logic
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_low      <= 24'd65536;
      grid_high     <= 24'd262144;
      lorentz_width <= 16'd4096;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_LOW:   grid_low      <= pwdata[23:0];
        REG_HIGH:  grid_high     <= pwdata[23:0];
        REG_WIDTH: lorentz_width <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOW:   prdata = {8'd0, grid_low};
      REG_HIGH:  prdata = {8'd0, grid_high};
      REG_WIDTH: prdata = {16'd0, lorentz_width};
      default:   prdata = '0;
    endcase
  end

  gble_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  gble_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .front_energy  (front_energy),
    .back_energy   (back_energy),
    .grid_low      (grid_low),
    .grid_high     (grid_high),
    .lorentz_width (lorentz_width),
    .peak_index    (peak_index),
    .peak_value    (peak_value),
    .p16_index     (p16_index),
    .p50_index     (p50_index),
    .p84_index     (p84_index),
    .found_flags   (found_flags),
    .event_count   (event_count),
    .input_error   (input_error)
  );

`ifndef NO_ASSERTIONS
  // a result never coincides with taking a new command
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while not busy");
  // cumulative sum is monotone, so percentiles are found in order
  a_flag_order1: assert property (@(posedge clk) disable iff (rst)
    (done && found_flags[1]) |-> found_flags[0])
    else $error("p50 found without p16");
  a_flag_order2: assert property (@(posedge clk) disable iff (rst)
    (done && found_flags[2]) |-> found_flags[1])
    else $error("p84 found without p50");
  a_idx_order: assert property (@(posedge clk) disable iff (rst)
    (done && found_flags[1]) |-> (p16_index <= p50_index))
    else $error("p16 index above p50 index");
`endif

endmodule
`default_nettype wire

>>> test/grid_bayes_lorentz_estimator_tb.sv
// Self-checking testbench for grid_bayes_lorentz_estimator.
// Depends on gble_pkg and the block's RTL. It predicts every result from
// its own copy of the grid and registers, and checks each transfer in order.
`default_nettype none
module grid_bayes_lorentz_estimator_tb;
  import gble_pkg::*;

  localparam int NCELL     = 256;
  localparam int WD_LIMIT  = 120000;
  localparam int IDLE_WAIT = 700;      // scan-only item latency plus margin

  // register byte addresses
  localparam logic [3:0] REG_GRID_LOW  = 4'd0;
  localparam logic [3:0] REG_GRID_HIGH = 4'd4;
  localparam logic [3:0] REG_WIDTH     = 4'd8;

  localparam logic OP_EVENT   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct {
    logic        op;
    logic [15:0] front;
    logic [15:0] back;
  } shot_t;

  typedef struct {
    logic [7:0]  peak_index;
    logic [31:0] peak_value;
    logic [7:0]  p16_index;
    logic [7:0]  p50_index;
    logic [7:0]  p84_index;
    logic [2:0]  found_flags;
    logic [31:0] event_count;
    logic        input_error;
  } estimate_t;

  logic clk, rst;
  logic start, busy, op;
  logic [15:0] front_energy, back_energy;
  logic done;
  logic [7:0] peak_index, p16_index, p50_index, p84_index;
  logic [31:0] peak_value, event_count;
  logic [2:0] found_flags;
  logic input_error;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  grid_bayes_lorentz_estimator dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .op(op),
    .front_energy(front_energy), .back_energy(back_energy),
    .done(done), .peak_index(peak_index), .peak_value(peak_value),
    .p16_index(p16_index), .p50_index(p50_index), .p84_index(p84_index),
    .found_flags(found_flags), .event_count(event_count), .input_error(input_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------------------------------------------------------------
  // Predictor state: mirror of the grid, trial count and registers.
  // ---------------------------------------------------------------------
  longint unsigned cells [NCELL];
  longint unsigned weighted [NCELL];
  logic [31:0] trial_cnt;
  longint unsigned cfg_low, cfg_high, cfg_width;

  shot_t     shots_pending[$];
  estimate_t estimates_due[$];
  int        n_errors;
  int        quiet_cycles;

  function automatic longint unsigned log2_fix(longint unsigned v);
    int msb;
    longint unsigned m, frac;
    msb = 0;
    frac = 0;
    if (v == 0) v = 1;
    while (msb < 29 && (v >> (msb + 1)) != 0) msb++;
    m = v << (30 - msb);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(msb) << 16) | frac;
  endfunction

  function automatic longint unsigned grid_pos(int i);
    longint unsigned x;
    if (cfg_high >= cfg_low)
      x = cfg_low + ((cfg_high - cfg_low) * longint'(i)) / NCELL;
    else
      x = cfg_low - ((cfg_low - cfg_high) * longint'(i)) / NCELL;
    return (x < 1) ? 64'd1 : x;
  endfunction

  function automatic void set_uniform();
    for (int i = 0; i < NCELL; i++) cells[i] = 64'd1 << 24;
  endfunction

  // Weight each cell by the Lorentz term, then renormalise by long division.
  function automatic void weigh_grid(longint unsigned fe, longint unsigned be);
    longint unsigned total, w16, a, d, den, g, r, q;
    longint signed base, dl;
    total = 0;
    w16 = cfg_width << 4;
    base = longint'(log2_fix(be)) - longint'(log2_fix(fe)) + (longint'(16) << 16);
    for (int i = 0; i < NCELL; i++) begin
      dl = base - longint'(log2_fix(grid_pos(i)));
      a = (dl < 0) ? longint'(-dl) : longint'(dl);
      d = (a * 45426 + 32768) >> 16;
      den = w16 * w16 + d * d;
      g = (den == 0) ? 64'hFFFF_FFFF : (64'd1 << 61) / den;
      if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
      weighted[i] = (cells[i] * g) >> 16;
      total += weighted[i];
    end
    if (total == 0) return;
    for (int i = 0; i < NCELL; i++) begin
      r = weighted[i];
      q = 0;
      if (r >= total) begin
        r -= total;
        q = 1;
      end
      for (int k = 0; k < 32; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= total) begin
          r -= total;
          q = q | 64'd1;
        end
      end
      cells[i] = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    end
  endfunction

  function automatic estimate_t estimate_shot(shot_t s);
    estimate_t e;
    longint unsigned best, cum;
    longint unsigned thr [3];
    int best_i;
    logic [2:0] flags;
    int idx [3];
    e.input_error = 1'b0;
    if (s.op == OP_RESTART) begin
      set_uniform();
      trial_cnt = '0;
    end else if (s.front == 0 || s.back == 0) begin
      e.input_error = 1'b1;
    end else begin
      weigh_grid(s.front, s.back);
      if (trial_cnt != 32'hFFFF_FFFF) trial_cnt++;
    end
    best = cells[0];
    best_i = 0;
    for (int i = 1; i < NCELL; i++)
      if (cells[i] > best) begin
        best = cells[i];
        best_i = i;
      end
    thr[0] = (64'd1 << 32) * 16 / 100;
    thr[1] = (64'd1 << 32) * 50 / 100;
    thr[2] = (64'd1 << 32) * 84 / 100;
    flags = '0;
    cum = 0;
    for (int j = 0; j < 3; j++) idx[j] = NCELL - 1;
    // last cell never counts as found
    for (int i = 0; i < NCELL - 1; i++) begin
      cum += cells[i];
      for (int j = 0; j < 3; j++)
        if (!flags[j] && cum > thr[j]) begin
          idx[j] = i;
          flags[j] = 1'b1;
        end
    end
    e.peak_index  = best_i[7:0];
    e.peak_value  = best[31:0];
    e.p16_index   = idx[0][7:0];
    e.p50_index   = idx[1][7:0];
    e.p84_index   = idx[2][7:0];
    e.found_flags = flags;
    e.event_count = trial_cnt;
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Command driver: bursts of transfers separated by random gaps.
  // The predictor runs on the edge where the transfer is accepted.
  // ---------------------------------------------------------------------
  int burst_left, gap_left;

  always @(posedge clk) begin
    shot_t nxt, cur;
    logic taken;
    if (rst) begin
      start <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        cur.op = op;
        cur.front = front_energy;
        cur.back = back_energy;
        estimates_due.insert(estimates_due.size(), estimate_shot(cur));
      end
      if (start && !taken) begin
        // hold the current command until accepted
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (shots_pending.size() > 0) begin
        nxt = shots_pending.pop_front();
        op <= nxt.op;
        front_energy <= nxt.front;
        back_energy <= nxt.back;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 6);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: each done pulse is one transfer, checked in order.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    estimate_t e;
    if (!rst && done) begin
      if (estimates_due.size() == 0) begin
        $error("result transfer with no expectation waiting");
        n_errors++;
      end else begin
        e = estimates_due.pop_front();
        if (peak_index !== e.peak_index) begin
          $error("peak_index exp %0d got %0d", e.peak_index, peak_index);
          n_errors++;
        end
        if (peak_value !== e.peak_value) begin
          $error("peak_value exp %h got %h", e.peak_value, peak_value);
          n_errors++;
        end
        if (p16_index !== e.p16_index) begin
          $error("p16_index exp %0d got %0d", e.p16_index, p16_index);
          n_errors++;
        end
        if (p50_index !== e.p50_index) begin
          $error("p50_index exp %0d got %0d", e.p50_index, p50_index);
          n_errors++;
        end
        if (p84_index !== e.p84_index) begin
          $error("p84_index exp %0d got %0d", e.p84_index, p84_index);
          n_errors++;
        end
        if (found_flags !== e.found_flags) begin
          $error("found_flags exp %b got %b", e.found_flags, found_flags);
          n_errors++;
        end
        if (event_count !== e.event_count) begin
          $error("event_count exp %0d got %0d", e.event_count, event_count);
          n_errors++;
        end
        if (input_error !== e.input_error) begin
          $error("input_error exp %b got %b", e.input_error, input_error);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("grid_bayes_lorentz_estimator_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic reg_write(logic [3:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);   // write lands on this edge
    case (addr)
      REG_GRID_LOW:  cfg_low = value & 32'hFF_FFFF;
      REG_GRID_HIGH: cfg_high = value & 32'hFF_FFFF;
      REG_WIDTH:     cfg_width = value & 32'hFFFF;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_shot(logic o, logic [15:0] f, logic [15:0] b);
    shot_t s;
    s.op = o;
    s.front = f;
    s.back = b;
    shots_pending.insert(shots_pending.size(), s);
  endtask

  // Wait for every result, then let any trailing work drain.
  task automatic drain();
    while (shots_pending.size() != 0 || start || estimates_due.size() != 0)
      @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random events, some shaped to the default span, zero-energy events and restarts.
  task automatic add_random(int n);
    int kind;
    logic [15:0] f, b;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      f = 16'($urandom_range(1, 65535));
      if (kind < 30) begin
        add_shot(OP_EVENT, f, 16'($urandom_range(1, 65535)));
      end else if (kind < 48) begin
        // back roughly front times a position inside the default span
        f = 16'($urandom_range(1, 16000));
        b = 16'(f * $urandom_range(1, 4) + $urandom_range(0, 255));
        add_shot(OP_EVENT, f, (b == 0) ? 16'd1 : b);
      end else if (kind < 80) begin
        // zero energy on one side or both: scan only
        case ($urandom_range(0, 2))
          0: add_shot(OP_EVENT, 16'd0, 16'($urandom));
          1: add_shot(OP_EVENT, 16'($urandom), 16'd0);
          default: add_shot(OP_EVENT, 16'd0, 16'd0);
        endcase
      end else begin
        add_shot(OP_RESTART, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = 1'b0;
    front_energy = '0;
    back_energy = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_errors = 0;
    quiet_cycles = 0;
    cfg_low = 65536;
    cfg_high = 262144;
    cfg_width = 4096;
    trial_cnt = '0;
    set_uniform();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: restart, zero energies, energy extremes
    add_shot(OP_RESTART, 16'hFFFF, 16'hFFFF);
    add_shot(OP_EVENT, 16'd0, 16'd100);
    add_shot(OP_EVENT, 16'd100, 16'd0);
    add_shot(OP_EVENT, 16'd0, 16'd0);
    add_shot(OP_EVENT, 16'd1, 16'd1);
    add_shot(OP_EVENT, 16'hFFFF, 16'hFFFF);
    add_shot(OP_EVENT, 16'd1, 16'hFFFF);
    add_shot(OP_EVENT, 16'hFFFF, 16'd1);
    add_shot(OP_EVENT, 16'd1000, 16'd2000);
    add_shot(OP_EVENT, 16'd1000, 16'd2000);
    add_shot(OP_EVENT, 16'd0, 16'd5);
    add_shot(OP_RESTART, 16'd0, 16'd0);
    add_shot(OP_EVENT, 16'hAAAA, 16'h5555);
    add_shot(OP_EVENT, 16'h5555, 16'hAAAA);
    add_random(100);
    drain();

    // lowest positions, widest span, narrowest width
    reg_write(REG_GRID_LOW, 32'd1);
    reg_write(REG_GRID_HIGH, 32'hFF_FFFF);
    reg_write(REG_WIDTH, 32'd1);
    add_shot(OP_RESTART, 16'd0, 16'd0);
    add_shot(OP_EVENT, 16'd1, 16'hFFFF);
    add_random(105);
    drain();

    // decreasing positions, widest width
    reg_write(REG_GRID_LOW, 32'hFF_FFFF);
    reg_write(REG_GRID_HIGH, 32'd1);
    reg_write(REG_WIDTH, 32'hFFFF);
    add_random(105);
    drain();

    // equal ends: every cell at the same position
    reg_write(REG_GRID_LOW, 32'h2_0000);
    reg_write(REG_GRID_HIGH, 32'h2_0000);
    reg_write(REG_WIDTH, 32'd300);
    add_shot(OP_RESTART, 16'd0, 16'd0);
    add_random(50);
    drain();

    // random settings with garbage in the upper bits
    for (int p = 0; p < 2; p++) begin
      reg_write(REG_GRID_LOW, $urandom);
      reg_write(REG_GRID_HIGH, $urandom);
      reg_write(REG_WIDTH, $urandom);
      add_shot(OP_RESTART, 16'd0, 16'd0);
      add_random(50);
      drain();
    end

    // back to reset values, narrow Lorentz
    reg_write(REG_GRID_LOW, 32'd65536);
    reg_write(REG_GRID_HIGH, 32'd262144);
    reg_write(REG_WIDTH, 32'd512);
    add_random(100);
    drain();

    if (n_errors == 0)
      $display("grid_bayes_lorentz_estimator_tb: done, clean");
    else
      $display("grid_bayes_lorentz_estimator_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

>>> grid_bayes_lorentz_estimator.f
sv/gble_pkg.sv
sv/gble_ctrl.sv
sv/gble_dp.sv
sv/grid_bayes_lorentz_estimator.sv
test/grid_bayes_lorentz_estimator_tb.sv
